FILE: rtl/tsrr_pkg.sv
// shared types, constants and codes for the round-robin / priority task scheduler
// no dependencies; used by the scheduler top level, its task table and its checker
package tsrr_pkg;

    localparam int SLOTS          = 8;
    localparam int SLOT_W         = 3;
    localparam int PRIO_W         = 8;
    localparam int COUNT_W        = 4;
    localparam int MODE_W         = 2;
    localparam int CFG_W          = 4;
    localparam int CFG_IDX_W      = 1;
    localparam int IN_DATA_W      = 16;
    localparam int OUT_DATA_W     = 8;
    localparam int USER_TASKS_DEF = 7;

    // task count register resets to the slot count
    localparam logic [COUNT_W-1:0] TASK_COUNT_RST = COUNT_W'(SLOTS);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT  = 1'b1;

    // item kinds carried in tuser
    localparam logic OP_WRITE    = 1'b0;
    localparam logic OP_SCHEDULE = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        POLICY_RR      = 2'd0,
        POLICY_PRIO    = 2'd1,
        POLICY_RR_PRIO = 2'd2
    } tsrr_policy_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_RR_SCAN,
        ST_PF_FIRST,
        ST_PF_SEEK,
        ST_PF_BEST,
        ST_PR_TOP,
        ST_PR_SCAN,
        ST_FINISH
    } tsrr_state_t;

    typedef struct packed {
        logic              ready;
        logic              idle;
        logic [PRIO_W-1:0] prio;
    } slot_entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        slot_entry_t       entry;
    } slot_wr_t;

endpackage

FILE: rtl/tsrr_table.sv
// task table: ready, idle-task and priority per slot, one write and one read port
// depends on tsrr_pkg
module tsrr_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tsrr_pkg::slot_wr_t          wr,
    input  logic [tsrr_pkg::SLOT_W-1:0] rd_addr,
    output tsrr_pkg::slot_entry_t       rd_entry
);

    tsrr_pkg::slot_entry_t slot_reg [tsrr_pkg::SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tsrr_pkg::SLOTS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            slot_reg[wr.addr] <= wr.entry;
        end
    end

    assign rd_entry = slot_reg[rd_addr];

endmodule

FILE: rtl/task_scheduler_rr_priority.sv
// top level of the task scheduler: stream ports, config registers, scan sequencer
// depends on tsrr_pkg and tsrr_table
//
// A write item (tuser low) stores ready, idle-task and priority into one slot
// and gives no result. A schedule item (tuser high) is worked through by a small
// sequencer that reads one table slot per cycle through a single read port and
// one compare/increment unit. It accepts the item, folds the running slot into
// the ring of n slots by repeated subtraction, runs the policy scan and then
// loads the output register: round-robin scans up to USER_TASKS slots, highest
// priority reads 1 + up to n slots to find a ready one plus up to n to compare
// priorities, round-robin within highest priority reads n slots for the top
// priority plus up to n for the search. The input side stays ready while an
// earlier result still waits on the output register.
module task_scheduler_rr_priority #(
    parameter int USER_TASKS = tsrr_pkg::USER_TASKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: task_slot[2:0], is_ready[3], is_idle_task[4], prio[12:5], zero
    input  logic [tsrr_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: opcode[0]
    input  logic                            s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: next_task[2:0], zero
    output logic [tsrr_pkg::OUT_DATA_W-1:0] m_tdata,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [tsrr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsrr_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int SLOT_W   = tsrr_pkg::SLOT_W;
    localparam int COUNT_W  = tsrr_pkg::COUNT_W;
    localparam int PRIO_W   = tsrr_pkg::PRIO_W;
    // scan counter covers both the round-robin window and the slot count
    localparam int SCAN_MAX = (USER_TASKS > tsrr_pkg::SLOTS) ? USER_TASKS : tsrr_pkg::SLOTS;
    localparam int CNT_W    = $clog2(SCAN_MAX + 1);
    localparam logic [CNT_W-1:0] RR_LAST = CNT_W'(USER_TASKS - 1);

    // control and configuration registers
    tsrr_pkg::tsrr_state_t     state_reg, state_next;
    logic [tsrr_pkg::MODE_W-1:0] policy_reg;
    logic [COUNT_W-1:0]        task_count_reg;
    logic [SLOT_W-1:0]         running_reg, running_next;
    logic                      m_valid_reg, m_valid_next;

    // working registers of the scan
    logic [SLOT_W-1:0]         p_reg, p_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [PRIO_W-1:0]         best_reg, best_next;
    logic [SLOT_W-1:0]         res_reg, res_next;
    logic [SLOT_W-1:0]         m_data_reg, m_data_next;

    // table access
    tsrr_pkg::slot_wr_t        tbl_wr;
    tsrr_pkg::slot_entry_t     entry;
    logic [SLOT_W-1:0]         rd_addr;

    // shared unit signals
    logic [COUNT_W-1:0]        n_eff;
    logic [CNT_W-1:0]          n_cnt;
    logic [SLOT_W-1:0]         p_inc;
    logic                      usable;
    logic                      norm_ge;
    logic                      in_xfer;
    logic                      out_free;

    // slot count clamped to 1..8
    always_comb
    begin
        priority if (task_count_reg == '0)
            n_eff = COUNT_W'(1);
        else if (task_count_reg > COUNT_W'(tsrr_pkg::SLOTS))
            n_eff = COUNT_W'(tsrr_pkg::SLOTS);
        else
            n_eff = task_count_reg;
    end

    assign n_cnt    = CNT_W'(n_eff);
    // p_reg is already below n here, so the wrap is a single compare
    assign p_inc    = (COUNT_W'(p_reg) + COUNT_W'(1) == n_eff) ? '0 : p_reg + SLOT_W'(1);
    assign norm_ge  = COUNT_W'(p_reg) >= n_eff;
    assign usable   = entry.ready && !entry.idle;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == tsrr_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(tsrr_pkg::OUT_DATA_W - SLOT_W){1'b0}}, m_data_reg};

    // slot write on a write transfer
    assign tbl_wr.en          = in_xfer && (s_tuser == tsrr_pkg::OP_WRITE);
    assign tbl_wr.addr        = s_tdata[2:0];
    assign tbl_wr.entry.ready = s_tdata[3];
    assign tbl_wr.entry.idle  = s_tdata[4];
    assign tbl_wr.entry.prio  = s_tdata[12:5];

    // one read address per cycle, picked by the sequencer
    always_comb
    begin
        unique case (state_reg)
            tsrr_pkg::ST_PF_FIRST: rd_addr = running_reg;
            tsrr_pkg::ST_PF_BEST,
            tsrr_pkg::ST_PR_TOP:   rd_addr = cnt_reg[SLOT_W-1:0];
            default:               rd_addr = p_inc;
        endcase
    end

    tsrr_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_addr  (rd_addr),
        .rd_entry (entry)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsrr_pkg::ST_IDLE:
            begin
                if (in_xfer && (s_tuser == tsrr_pkg::OP_SCHEDULE))
                    state_next = tsrr_pkg::ST_NORM;
            end
            tsrr_pkg::ST_NORM:
            begin
                if (!norm_ge)
                begin
                    unique case (policy_reg)
                        tsrr_pkg::POLICY_PRIO:    state_next = tsrr_pkg::ST_PF_FIRST;
                        tsrr_pkg::POLICY_RR_PRIO: state_next = tsrr_pkg::ST_PR_TOP;
                        default:                  state_next = tsrr_pkg::ST_RR_SCAN;
                    endcase
                end
            end
            tsrr_pkg::ST_RR_SCAN:
            begin
                if (usable || (cnt_reg == RR_LAST))
                    state_next = tsrr_pkg::ST_FINISH;
            end
            tsrr_pkg::ST_PF_FIRST:
            begin
                state_next = entry.ready ? tsrr_pkg::ST_PF_BEST : tsrr_pkg::ST_PF_SEEK;
            end
            tsrr_pkg::ST_PF_SEEK:
            begin
                priority if (entry.ready)
                    state_next = tsrr_pkg::ST_PF_BEST;
                else if (cnt_reg == n_cnt - CNT_W'(1))
                    state_next = tsrr_pkg::ST_FINISH;
            end
            tsrr_pkg::ST_PF_BEST:
            begin
                if (cnt_reg >= n_cnt - CNT_W'(1))
                    state_next = tsrr_pkg::ST_FINISH;
            end
            tsrr_pkg::ST_PR_TOP:
            begin
                if (cnt_reg == n_cnt - CNT_W'(1))
                    state_next = tsrr_pkg::ST_PR_SCAN;
            end
            tsrr_pkg::ST_PR_SCAN:
            begin
                if ((usable && (entry.prio == best_reg)) || (cnt_reg == n_cnt))
                    state_next = tsrr_pkg::ST_FINISH;
            end
            tsrr_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = tsrr_pkg::ST_IDLE;
            end
            default: state_next = tsrr_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        p_next       = p_reg;
        cnt_next     = cnt_reg;
        best_next    = best_reg;
        res_next     = res_reg;
        running_next = running_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            tsrr_pkg::ST_IDLE:
            begin
                p_next = running_reg;
            end
            tsrr_pkg::ST_NORM:
            begin
                // fold the running slot into 0..n-1 by repeated subtraction
                if (norm_ge)
                    p_next = SLOT_W'(COUNT_W'(p_reg) - n_eff);
                cnt_next  = '0;
                best_next = '0;
            end
            tsrr_pkg::ST_RR_SCAN:
            begin
                p_next   = p_inc;
                cnt_next = cnt_reg + CNT_W'(1);
                res_next = usable ? p_inc : '0;
            end
            tsrr_pkg::ST_PF_FIRST:
            begin
                // the running slot itself is checked first, even beyond n
                if (entry.ready)
                begin
                    res_next  = running_reg;
                    best_next = entry.prio;
                    cnt_next  = CNT_W'(1);
                end
            end
            tsrr_pkg::ST_PF_SEEK:
            begin
                p_next = p_inc;
                if (entry.ready)
                begin
                    res_next  = p_inc;
                    best_next = entry.prio;
                    cnt_next  = CNT_W'(1);
                end
                else
                begin
                    res_next = '0;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            tsrr_pkg::ST_PF_BEST:
            begin
                // strictly higher priority wins, scanning slots 1..n-1
                if ((cnt_reg < n_cnt) && entry.ready && (entry.prio > best_reg))
                begin
                    res_next  = cnt_reg[SLOT_W-1:0];
                    best_next = entry.prio;
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            tsrr_pkg::ST_PR_TOP:
            begin
                if (usable && (entry.prio > best_reg))
                    best_next = entry.prio;
                cnt_next = (cnt_reg == n_cnt - CNT_W'(1)) ? CNT_W'(1) : cnt_reg + CNT_W'(1);
            end
            tsrr_pkg::ST_PR_SCAN:
            begin
                // n steps around the ring: the last one lands on the start slot,
                // which is the only candidate left for the lowest-index fallback
                p_next   = p_inc;
                cnt_next = cnt_reg + CNT_W'(1);
                res_next = (usable && (entry.prio == best_reg)) ? p_inc : '0;
            end
            tsrr_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    running_next = res_reg;
                end
            end
            default:
            begin
                p_next = p_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tsrr_pkg::ST_IDLE;
            running_reg    <= '0;
            m_valid_reg    <= 1'b0;
            policy_reg     <= tsrr_pkg::POLICY_RR;
            task_count_reg <= tsrr_pkg::TASK_COUNT_RST;
        end
        else
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tsrr_pkg::REG_POLICY_MODE: policy_reg     <= cfg_wdata[tsrr_pkg::MODE_W-1:0];
                    tsrr_pkg::REG_TASK_COUNT:  task_count_reg <= cfg_wdata[COUNT_W-1:0];
                    default:                   policy_reg     <= policy_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        cnt_reg    <= cnt_next;
        best_reg   <= best_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule

FILE: rtl/tsrr_checker.sv
// port-level checker for the task scheduler, bound to the top level
// depends on tsrr_pkg and task_scheduler_rr_priority
module tsrr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tsrr_pkg::OUT_DATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // a write transfer never produces a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == tsrr_pkg::OP_WRITE) && !m_tvalid |=> !m_tvalid)
        else $error("write transfer produced a result");

    // a schedule transfer occupies the sequencer
    a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == tsrr_pkg::OP_SCHEDULE) |=> !s_tready)
        else $error("input ready right after a schedule transfer");

    // a result appears only out of a busy sequencer
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised while sequencer idle");

endmodule

bind task_scheduler_rr_priority tsrr_checker u_tsrr_checker (.*);

FILE: tb/task_scheduler_rr_priority_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the round-robin / priority task scheduler
// depends on tsrr_pkg and the task_scheduler_rr_priority rtl

// keeps its own copy of the task table, the running slot and the two registers,
// works out next_task for every accepted schedule transfer and checks the results
class next_task_scoreboard;
    logic [tsrr_pkg::MODE_W-1:0]  policy;
    logic [tsrr_pkg::COUNT_W-1:0] task_count;
    tsrr_pkg::slot_entry_t        slot_table [tsrr_pkg::SLOTS];
    logic [tsrr_pkg::SLOT_W-1:0]  running_slot;
    logic [tsrr_pkg::SLOT_W-1:0]  expected_next [$];
    int                           fault_count;

    function new();
        policy       = tsrr_pkg::POLICY_RR;
        task_count   = tsrr_pkg::TASK_COUNT_RST;
        foreach (slot_table[i])
            slot_table[i] = '0;
        running_slot = '0;
        fault_count  = 0;
    endfunction

    function void note_fault(string msg);
        if (fault_count < 10)
            $display("%s", msg);
        fault_count++;
    endfunction

    function void set_reg(logic [tsrr_pkg::CFG_IDX_W-1:0] idx,
                          logic [tsrr_pkg::CFG_W-1:0] value);
        if (idx == tsrr_pkg::REG_POLICY_MODE)
            policy = value[tsrr_pkg::MODE_W-1:0];
        else
            task_count = value[tsrr_pkg::COUNT_W-1:0];
    endfunction

    // zero counts as one slot, anything past the table as the whole table
    function int ring_size();
        if (task_count == 0)
            return 1;
        if (task_count > tsrr_pkg::SLOTS)
            return tsrr_pkg::SLOTS;
        return int'(task_count);
    endfunction

    function bit runnable(int s);
        return slot_table[s].ready && !slot_table[s].idle;
    endfunction

    // next ready non-idle slot after the running one, USER_TASKS steps at most
    function int pick_round_robin(int n);
        int p;
        p = int'(running_slot);
        for (int k = 0; k < tsrr_pkg::USER_TASKS_DEF; k++)
        begin
            p = (p + 1) % n;
            if (runnable(p))
                return p;
        end
        return 0;
    endfunction

    // first ready slot from the running one (idle bit ignored), then any
    // strictly more urgent ready slot among 1..n-1
    function int pick_highest(int n);
        int p;
        int best;
        bit found;
        p     = int'(running_slot);
        found = 1'b0;
        for (int k = 0; k <= n; k++)
        begin
            if (slot_table[p].ready)
            begin
                found = 1'b1;
                break;
            end
            p = (p + 1) % n;
        end
        if (!found)
            return 0;
        best = slot_table[p].prio;
        for (int i = 1; i < n; i++)
        begin
            if (slot_table[i].ready && slot_table[i].prio > best)
            begin
                p    = i;
                best = slot_table[i].prio;
            end
        end
        return p;
    endfunction

    // round-robin among the runnable slots at the top priority
    function int pick_top_rr(int n);
        int top;
        int p;
        top = 0;
        for (int i = 0; i < n; i++)
            if (runnable(i) && slot_table[i].prio > top)
                top = slot_table[i].prio;
        p = int'(running_slot);
        for (int k = 1; k < n; k++)
        begin
            p = (p + 1) % n;
            if (runnable(p) && slot_table[p].prio == top)
                return p;
        end
        for (int i = 0; i < n; i++)
            if (runnable(i) && slot_table[i].prio == top)
                return i;
        return 0;
    endfunction

    function void note_item(logic op, logic [tsrr_pkg::IN_DATA_W-1:0] data);
        int n;
        int pick;
        if (op == tsrr_pkg::OP_WRITE)
        begin
            slot_table[data[2:0]].ready = data[3];
            slot_table[data[2:0]].idle  = data[4];
            slot_table[data[2:0]].prio  = data[12:5];
            return;
        end
        n = ring_size();
        case (policy)
            tsrr_pkg::POLICY_PRIO:    pick = pick_highest(n);
            tsrr_pkg::POLICY_RR_PRIO: pick = pick_top_rr(n);
            default:                  pick = pick_round_robin(n);
        endcase
        running_slot = tsrr_pkg::SLOT_W'(pick);
        expected_next.push_back(tsrr_pkg::SLOT_W'(pick));
    endfunction

    function void check_result(logic [tsrr_pkg::OUT_DATA_W-1:0] data);
        logic [tsrr_pkg::SLOT_W-1:0] want;
        if (expected_next.size() == 0)
        begin
            note_fault($sformatf("next_task %0d arrived with nothing expected",
                                 data[tsrr_pkg::SLOT_W-1:0]));
            return;
        end
        want = expected_next.pop_front();
        if (data[tsrr_pkg::SLOT_W-1:0] !== want)
            note_fault($sformatf("next_task mismatch: expected %0d, got %0d",
                                 want, data[tsrr_pkg::SLOT_W-1:0]));
    endfunction

    function void report_leftover();
        if (expected_next.size() != 0)
            note_fault($sformatf("%0d next_task results never arrived",
                                 expected_next.size()));
    endfunction
endclass

module task_scheduler_rr_priority_tb;

    // unused policy code, behaves as round-robin
    localparam logic [tsrr_pkg::MODE_W-1:0] POLICY_SPARE = 2'd3;

    localparam int USER_TASKS      = tsrr_pkg::USER_TASKS_DEF;
    // a schedule decision folds the running slot, runs up to two scans of eight
    // slots and loads the output register
    localparam int SETTLE_CYCLES   = 48;
    // longest quiet stretch of a correct run: a full decision plus a long
    // receiver stall, or a settle pause; taken many times over
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int BLOCKS          = 14;
    localparam int ITEMS_PER_BLOCK = 118;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    // tdata: task_slot[2:0], is_ready[3], is_idle_task[4], prio[12:5], zero
    logic [tsrr_pkg::IN_DATA_W-1:0]  s_tdata;
    // tuser: opcode[0]
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    // tdata: next_task[2:0], zero
    logic [tsrr_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_we;
    logic [tsrr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tsrr_pkg::CFG_W-1:0]      cfg_wdata;

    // idle odds in percent for the sender and the receiver
    int gap_pct;
    int stall_pct;
    int quiet_cycles;

    // register settings per random block, extremes and the spare code included
    logic [tsrr_pkg::MODE_W-1:0] blk_mode [BLOCKS] = '{
        tsrr_pkg::POLICY_RR,      tsrr_pkg::POLICY_PRIO,    tsrr_pkg::POLICY_RR_PRIO,
        POLICY_SPARE,             tsrr_pkg::POLICY_PRIO,    tsrr_pkg::POLICY_RR_PRIO,
        tsrr_pkg::POLICY_RR,      tsrr_pkg::POLICY_RR_PRIO, tsrr_pkg::POLICY_PRIO,
        tsrr_pkg::POLICY_RR,      tsrr_pkg::POLICY_RR_PRIO, tsrr_pkg::POLICY_PRIO,
        tsrr_pkg::POLICY_RR_PRIO, tsrr_pkg::POLICY_RR};
    int blk_count [BLOCKS] = '{8, 8, 8, 5, 0, 15, 1, 3, 12, 9, 2, 6, 1, 4};

    next_task_scoreboard sched_sb = new();

    task_scheduler_rr_priority #(
        .USER_TASKS (USER_TASKS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // receiver side: tready changes on the falling edge only
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // monitors: sample at the rising edge, before the block's own updates land
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sched_sb.note_item(s_tuser, s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sched_sb.check_result(m_tdata);
        if (rst_n && cfg_we)
            sched_sb.set_reg(cfg_index, cfg_wdata);
    end

    // watchdog: any transfer on either side restarts the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("task_scheduler_rr_priority_tb failed");
            $finish;
        end
    end

    // one input transfer; random gaps before raising tvalid, then hold until taken
    task automatic send_item(input logic op, input logic [tsrr_pkg::IN_DATA_W-1:0] data);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_write(input logic [tsrr_pkg::SLOT_W-1:0] slot, input logic rdy,
                              input logic idl, input logic [tsrr_pkg::PRIO_W-1:0] pri);
        send_item(tsrr_pkg::OP_WRITE, {3'b000, pri, idl, rdy, slot});
    endtask

    // payload of a schedule transfer is don't-care, so it carries noise
    task automatic send_schedule();
        send_item(tsrr_pkg::OP_SCHEDULE, {3'b000, 13'($urandom_range(8191))});
    endtask

    // sender holds off until every decision is back, then lets the block go quiet,
    // since a trailing write never shows up on the result side
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sched_sb.expected_next.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tsrr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tsrr_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // priorities bunch on a few values so ties at the top show up often
    task automatic send_random_item();
        logic [tsrr_pkg::PRIO_W-1:0] pri;
        case ($urandom_range(3))
            0:       pri = tsrr_pkg::PRIO_W'($urandom_range(255));
            1:       pri = '1;
            default: pri = tsrr_pkg::PRIO_W'($urandom_range(2));
        endcase
        if ($urandom_range(99) < 45)
            send_schedule();
        else
            send_write(tsrr_pkg::SLOT_W'($urandom_range(7)), ($urandom_range(9) < 7),
                       ($urandom_range(9) < 2), pri);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = tsrr_pkg::OP_WRITE;
        cfg_we    = 1'b0;
        cfg_index = tsrr_pkg::REG_POLICY_MODE;
        cfg_wdata = '0;
        gap_pct   = 0;
        stall_pct = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // round-robin from reset: empty table, then 3 and 7, then wrap past the idle slot to 3
        send_schedule();
        send_write(3'd7, 1'b1, 1'b0, 8'd255);
        send_write(3'd0, 1'b1, 1'b1, 8'd0);
        send_write(3'd3, 1'b1, 1'b0, 8'd128);
        send_schedule();
        send_schedule();
        send_schedule();

        // highest priority: top priority wins, then falls back once it drops out
        settle();
        write_reg(tsrr_pkg::REG_POLICY_MODE, tsrr_pkg::CFG_W'(tsrr_pkg::POLICY_PRIO));
        send_schedule();
        send_write(3'd7, 1'b0, 1'b0, 8'd255);
        send_schedule();

        // round-robin within top priority: two slots tie at 128
        settle();
        write_reg(tsrr_pkg::REG_POLICY_MODE, tsrr_pkg::CFG_W'(tsrr_pkg::POLICY_RR_PRIO));
        send_write(3'd5, 1'b1, 1'b0, 8'd128);
        send_schedule();
        send_schedule();
        send_schedule();

        // spare policy code with a zero task count, running slot past the ring
        settle();
        write_reg(tsrr_pkg::REG_POLICY_MODE, tsrr_pkg::CFG_W'(POLICY_SPARE));
        write_reg(tsrr_pkg::REG_TASK_COUNT, 4'd0);
        send_schedule();

        // highest priority with count past the table: idle bit ignored,
        // then nothing ready at all must give slot 0, then ready idle slot 6 is taken
        settle();
        write_reg(tsrr_pkg::REG_POLICY_MODE, tsrr_pkg::CFG_W'(tsrr_pkg::POLICY_PRIO));
        write_reg(tsrr_pkg::REG_TASK_COUNT, 4'd15);
        send_write(3'd3, 1'b0, 1'b0, 8'd0);
        send_write(3'd5, 1'b0, 1'b1, 8'd0);
        send_schedule();
        send_write(3'd0, 1'b0, 1'b0, 8'd0);
        send_schedule();
        send_write(3'd6, 1'b1, 1'b1, 8'd1);
        send_schedule();

        // random blocks, each with its own register setting and idle pattern
        for (int b = 0; b < BLOCKS; b++)
        begin
            settle();
            // upper bits of the policy write are noise the block must drop
            write_reg(tsrr_pkg::REG_POLICY_MODE, {2'($urandom_range(3)), blk_mode[b]});
            write_reg(tsrr_pkg::REG_TASK_COUNT, tsrr_pkg::CFG_W'(blk_count[b]));
            case (b % 4)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 79;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 79;
                end
                default:
                begin
                    gap_pct   = 19;
                    stall_pct = 19;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_BLOCK; i++)
            begin
                // now and then drain mid-block with the block's state intact
                if ($urandom_range(199) == 0)
                    settle();
                send_random_item();
            end
        end

        settle();
        sched_sb.report_leftover();
        if (sched_sb.fault_count == 0)
            $display("task_scheduler_rr_priority_tb passed");
        else
            $display("task_scheduler_rr_priority_tb failed");
        $finish;
    end

endmodule

FILE: task_scheduler_rr_priority.f
rtl/tsrr_pkg.sv
rtl/tsrr_table.sv
rtl/task_scheduler_rr_priority.sv
rtl/tsrr_checker.sv
tb/task_scheduler_rr_priority_tb.sv
